FILE: hdl/plin3_pkg.sv
// Shared types and constants for the piecewise linear 3-D interpolator.
// Used by plin3_lane and piecewise_linear_3d_interpolator_unit; no dependencies.

package plin3_pkg;

    localparam int MAX_KNOTS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int SEG_W         = 6;
    localparam int NUM_AXES      = 3;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_EXTRAP   = 3'd1,
        STS_FEW      = 3'd2,
        STS_NOT_INCR = 3'd3,
        STS_FULL     = 3'd4
    } status_t;

    // Control that the sequencer sends to every axis lane.
    typedef struct packed {
        logic wr_base;
        logic div_start;
        logic mul_en;
        logic add_en;
    } lane_ctrl_t;

endpackage

FILE: hdl/piecewise_linear_3d_interpolator_unit.sv
// Top level of the piecewise linear 3-D interpolator: sequencer, knot time
// memory, segment search and output register. Depends on plin3_pkg, plin3_lane.

// The block keeps a table of up to MAX_KNOTS knots (time plus x, y, z, all
// signed fixed point with FRAC_BITS fraction bits) and handles one input
// transfer at a time, returning exactly one result transfer for each. A clear,
// an unused opcode, a rejected append or a query that gets STS_FEW or
// STS_EXTRAP goes from the input transfer straight to the final state, which
// loads the output register. An append that creates a segment runs a radix-2
// divider in each of the three axis lanes in parallel, one quotient bit per
// cycle, and waits in ST_DIV until all three are done. Any other query that
// lands outside the knot range or on an end knot passes through ST_FETCH,
// ST_MUL and ST_ADD; an interior query first runs a binary search over the
// knot time memory, each probe reading through its registered read port in
// ST_SRD and comparing in ST_SCMP. The three lanes then evaluate slope times
// offset plus base side by side and a merging step ORs their saturation flags.
// A new input transfer is taken once the result before it has moved into the
// output register; the output register holds a result while out_stall is high.

module piecewise_linear_3d_interpolator_unit #(
    parameter int MAX_KNOTS = plin3_pkg::MAX_KNOTS_DEF,
    parameter int FRAC_BITS = plin3_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           opcode,
    input  logic signed [plin3_pkg::COORD_W-1:0] time_req,
    input  logic signed [plin3_pkg::COORD_W-1:0] x_in,
    input  logic signed [plin3_pkg::COORD_W-1:0] y_in,
    input  logic signed [plin3_pkg::COORD_W-1:0] z_in,
    input  logic                                 allow_extrapolate,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [plin3_pkg::COORD_W-1:0] x_out,
    output logic signed [plin3_pkg::COORD_W-1:0] y_out,
    output logic signed [plin3_pkg::COORD_W-1:0] z_out,
    output logic [plin3_pkg::SEG_W-1:0]          segment,
    output logic [2:0]                           status,
    output logic                                 saturated
);

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int DW = plin3_pkg::COORD_W;
    localparam int NA = plin3_pkg::NUM_AXES;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRD,
        ST_SCMP,
        ST_FETCH,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg;

    logic [CW-1:0]          count_reg;
    logic signed [DW-1:0]   first_time_reg;
    logic signed [DW-1:0]   last_time_reg;
    logic signed [DW-1:0]   t_reg;
    logic [AW-1:0]          lo_reg;
    logic [AW-1:0]          hi_reg;
    logic [AW-1:0]          mid_reg;
    logic [AW-1:0]          idx_reg;
    logic [plin3_pkg::SEG_W-1:0] seg_reg;
    plin3_pkg::status_t     status_reg;
    logic                   use_res_reg;
    logic                   use_slope_reg;

    logic                   out_valid_reg;
    logic signed [DW-1:0]   x_out_reg;
    logic signed [DW-1:0]   y_out_reg;
    logic signed [DW-1:0]   z_out_reg;
    logic [plin3_pkg::SEG_W-1:0] segment_reg;
    logic [2:0]             status_out_reg;
    logic                   saturated_reg;

    logic signed [DW-1:0]   times_mem [MAX_KNOTS];
    logic signed [DW-1:0]   times_rd_reg;

    logic                   accept;
    plin3_pkg::opcode_t     op;
    logic                   is_full;
    logic                   bad_time;
    logic                   app_ok;
    logic [DW:0]            dt_wide;
    logic signed [DW:0]     dt_mul;
    logic [AW-1:0]          mid_c;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          slope_addr;
    logic [AW-1:0]          last_seg;
    logic                   out_free;
    plin3_pkg::lane_ctrl_t  ctrl;

    logic signed [DW-1:0]   coord   [NA];
    logic signed [DW-1:0]   res     [NA];
    logic [NA-1:0]          div_busy;
    logic [NA-1:0]          slope_sat;
    logic [NA-1:0]          res_sat;

    assign coord[0] = x_in;
    assign coord[1] = y_in;
    assign coord[2] = z_in;

    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && !in_stall;
    assign op       = plin3_pkg::opcode_t'(opcode);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        is_full  = count_reg == CW'(MAX_KNOTS);
        bad_time = (count_reg != '0) && (time_req <= last_time_reg);
        app_ok   = accept && (op == plin3_pkg::OP_APPEND) && !is_full && !bad_time;

        // Positive after the increasing-time check, so 32 bits carry it.
        dt_wide  = {time_req[DW-1], time_req} - {last_time_reg[DW-1], last_time_reg};
        dt_mul   = {t_reg[DW-1], t_reg} - {times_rd_reg[DW-1], times_rd_reg};

        mid_c      = AW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
        rd_addr    = (state_reg == ST_SRD) ? mid_c : idx_reg;
        wr_addr    = count_reg[AW-1:0];
        slope_addr = AW'(count_reg - 1'b1);
        last_seg   = AW'(count_reg - CW'(2));

        ctrl.wr_base   = app_ok;
        ctrl.div_start = app_ok && (count_reg != '0);
        ctrl.mul_en    = state_reg == ST_MUL;
        ctrl.add_en    = state_reg == ST_ADD;
    end

    always_ff @(posedge clk)
    begin
        if (app_ok)
        begin
            times_mem[wr_addr] <= time_req;
        end
        times_rd_reg <= times_mem[rd_addr];
    end

    for (genvar a = 0; a < NA; a++)
    begin : g_lane
        plin3_lane #(
            .MAX_KNOTS (MAX_KNOTS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .coord      (coord[a]),
            .wr_addr    (wr_addr),
            .slope_addr (slope_addr),
            .rd_addr    (rd_addr),
            .dt_div     (dt_wide[DW-1:0]),
            .dt_mul     (dt_mul),
            .div_busy   (div_busy[a]),
            .slope_sat  (slope_sat[a]),
            .res        (res[a]),
            .res_sat    (res_sat[a])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            first_time_reg <= '0;
            last_time_reg  <= '0;
            t_reg          <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            mid_reg        <= '0;
            idx_reg        <= '0;
            seg_reg        <= '0;
            status_reg     <= plin3_pkg::STS_OK;
            use_res_reg    <= 1'b0;
            use_slope_reg  <= 1'b0;
            x_out_reg      <= '0;
            y_out_reg      <= '0;
            z_out_reg      <= '0;
            segment_reg    <= '0;
            status_out_reg <= '0;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        t_reg         <= time_req;
                        status_reg    <= plin3_pkg::STS_OK;
                        seg_reg       <= '0;
                        use_res_reg   <= 1'b0;
                        use_slope_reg <= 1'b0;
                        state_reg     <= ST_FIN;
                        case (op)
                            plin3_pkg::OP_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            plin3_pkg::OP_APPEND:
                            begin
                                if (is_full)
                                begin
                                    status_reg <= plin3_pkg::STS_FULL;
                                end
                                else if (bad_time)
                                begin
                                    status_reg <= plin3_pkg::STS_NOT_INCR;
                                end
                                else
                                begin
                                    count_reg     <= count_reg + 1'b1;
                                    last_time_reg <= time_req;
                                    if (count_reg == '0)
                                    begin
                                        first_time_reg <= time_req;
                                    end
                                    else
                                    begin
                                        seg_reg       <= plin3_pkg::SEG_W'(slope_addr);
                                        use_slope_reg <= 1'b1;
                                        state_reg     <= ST_DIV;
                                    end
                                end
                            end
                            plin3_pkg::OP_QUERY:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    status_reg <= plin3_pkg::STS_FEW;
                                end
                                else if (time_req >= last_time_reg)
                                begin
                                    idx_reg <= last_seg;
                                    seg_reg <= plin3_pkg::SEG_W'(last_seg);
                                    if (time_req > last_time_reg && !allow_extrapolate)
                                    begin
                                        status_reg <= plin3_pkg::STS_EXTRAP;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_FETCH;
                                    end
                                end
                                else if (time_req <= first_time_reg)
                                begin
                                    idx_reg <= '0;
                                    if (time_req < first_time_reg && !allow_extrapolate)
                                    begin
                                        status_reg <= plin3_pkg::STS_EXTRAP;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_FETCH;
                                    end
                                end
                                else
                                begin
                                    // Interior: times[lo] <= t < times[hi] holds.
                                    lo_reg    <= '0;
                                    hi_reg    <= AW'(count_reg - 1'b1);
                                    state_reg <= ST_SRD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                ST_SRD:
                begin
                    if (hi_reg == lo_reg + 1'b1)
                    begin
                        idx_reg   <= lo_reg;
                        seg_reg   <= plin3_pkg::SEG_W'(lo_reg);
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        mid_reg   <= mid_c;
                        state_reg <= ST_SCMP;
                    end
                end

                ST_SCMP:
                begin
                    if (times_rd_reg <= t_reg)
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= ST_SRD;
                end

                ST_FETCH:
                begin
                    state_reg <= ST_MUL;
                end

                ST_MUL:
                begin
                    state_reg <= ST_ADD;
                end

                ST_ADD:
                begin
                    use_res_reg <= 1'b1;
                    state_reg   <= ST_FIN;
                end

                ST_DIV:
                begin
                    if (div_busy == '0)
                    begin
                        state_reg <= ST_FIN;
                    end
                end

                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        x_out_reg      <= use_res_reg ? res[0] : '0;
                        y_out_reg      <= use_res_reg ? res[1] : '0;
                        z_out_reg      <= use_res_reg ? res[2] : '0;
                        segment_reg    <= seg_reg;
                        status_out_reg <= status_reg;
                        // Merge the lanes: any clamped axis flags the transfer.
                        saturated_reg  <= use_res_reg   ? (|res_sat) :
                                          use_slope_reg ? (|slope_sat) : 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign x_out     = x_out_reg;
    assign y_out     = y_out_reg;
    assign z_out     = z_out_reg;
    assign segment   = segment_reg;
    assign status    = status_out_reg;
    assign saturated = saturated_reg;

endmodule

FILE: hdl/plin3_lane.sv
// One axis lane: knot coordinate and slope memories, a radix-2 slope divider
// and the multiply-add that evaluates a segment. Depends on plin3_pkg.

module plin3_lane #(
    parameter int MAX_KNOTS = plin3_pkg::MAX_KNOTS_DEF,
    parameter int FRAC_BITS = plin3_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plin3_pkg::lane_ctrl_t               ctrl,
    input  logic signed [plin3_pkg::COORD_W-1:0] coord,
    input  logic [$clog2(MAX_KNOTS)-1:0]        wr_addr,
    input  logic [$clog2(MAX_KNOTS)-1:0]        slope_addr,
    input  logic [$clog2(MAX_KNOTS)-1:0]        rd_addr,
    input  logic [plin3_pkg::COORD_W-1:0]       dt_div,
    input  logic signed [plin3_pkg::COORD_W:0]  dt_mul,
    output logic                                div_busy,
    output logic                                slope_sat,
    output logic signed [plin3_pkg::COORD_W-1:0] res,
    output logic                                res_sat
);

    localparam int AW  = $clog2(MAX_KNOTS);
    localparam int CW  = plin3_pkg::COORD_W;
    localparam int DW  = CW + 1 + FRAC_BITS;
    localparam int NW  = $clog2(DW + 1);
    localparam int PW  = 2 * CW + 1;

    logic signed [CW-1:0] base_mem  [MAX_KNOTS];
    logic signed [CW-1:0] slope_mem [MAX_KNOTS];
    logic signed [CW-1:0] base_rd_reg;
    logic signed [CW-1:0] slope_rd_reg;
    logic signed [CW-1:0] last_coord_reg;

    logic [DW-1:0] num_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] dt_reg;
    logic [AW-1:0] saddr_reg;
    logic [NW-1:0] cnt_reg;
    logic          neg_reg;
    logic          busy_reg;
    logic          slope_sat_reg;

    logic signed [PW-1:0] prod_reg;
    logic signed [CW-1:0] res_reg;
    logic                 res_sat_reg;

    logic signed [CW:0]   dc;
    logic [CW:0]          dc_mag;
    logic [CW:0]          rem_sh;
    logic                 qbit;
    logic [DW-1:0]        q_hi;
    logic                 pos_ovf;
    logic                 neg_ovf;
    logic signed [CW-1:0] slope_next;
    logic                 slope_sat_next;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] shifted;
    logic signed [PW:0]   sum;
    logic signed [CW-1:0] res_next;
    logic                 res_sat_next;

    always_comb
    begin
        dc     = {coord[CW-1], coord} - {last_coord_reg[CW-1], last_coord_reg};
        dc_mag = dc[CW] ? (~dc + 1'b1) : dc;
        rem_sh = {rem_reg, num_reg[DW-1]};
        qbit   = rem_sh >= {1'b0, dt_reg};

        // The quotient magnitude sits in num_reg once all bits are shifted in.
        q_hi    = num_reg >> 31;
        pos_ovf = q_hi != '0;
        neg_ovf = (q_hi > DW'(1)) || ((q_hi == DW'(1)) && (num_reg[30:0] != '0));
        slope_sat_next = neg_reg ? neg_ovf : pos_ovf;
        if (neg_reg)
        begin
            slope_next = neg_ovf ? {1'b1, {(CW-1){1'b0}}} : -$signed(num_reg[CW-1:0]);
        end
        else
        begin
            slope_next = pos_ovf ? {1'b0, {(CW-1){1'b1}}} : $signed(num_reg[CW-1:0]);
        end

        prod_next = slope_rd_reg * dt_mul;
        shifted   = prod_reg >>> FRAC_BITS;
        sum       = {shifted[PW-1], shifted} + {{(PW+1-CW){base_rd_reg[CW-1]}}, base_rd_reg};
        res_sat_next = sum[PW:CW-1] != {(PW+2-CW){sum[PW]}};
        if (res_sat_next)
        begin
            res_next = sum[PW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            res_next = sum[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_base)
        begin
            base_mem[wr_addr] <= coord;
        end
        if (busy_reg && cnt_reg == '0)
        begin
            slope_mem[saddr_reg] <= slope_next;
        end
        base_rd_reg  <= base_mem[rd_addr];
        slope_rd_reg <= slope_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_base)
        begin
            last_coord_reg <= coord;
        end
        if (ctrl.div_start)
        begin
            num_reg   <= DW'(dc_mag) << FRAC_BITS;
            rem_reg   <= '0;
            dt_reg    <= dt_div;
            neg_reg   <= dc[CW];
            saddr_reg <= slope_addr;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            num_reg <= {num_reg[DW-2:0], qbit};
            rem_reg <= qbit ? CW'(rem_sh - {1'b0, dt_reg}) : rem_sh[CW-1:0];
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.add_en)
        begin
            res_reg     <= res_next;
            res_sat_reg <= res_sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            slope_sat_reg <= 1'b0;
        end
        else if (ctrl.div_start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= NW'(DW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg      <= 1'b0;
                slope_sat_reg <= slope_sat_next;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign div_busy  = busy_reg;
    assign slope_sat = slope_sat_reg;
    assign res       = res_reg;
    assign res_sat   = res_sat_reg;

endmodule
